// ===== hdl/iir_pkg.sv =====
// ----------------------------------------------------------------------------
// iir_pkg
// Shared constants and types of the direct form I IIR filter.
// ----------------------------------------------------------------------------
package iir_pkg;
  localparam int MAX_ORDER  = 3;
  localparam int HIST_DEPTH = 3;
  localparam int NUM_REGS   = 7;
  localparam int NUM_TERMS  = 1 + 2 * MAX_ORDER;
  localparam int SMP_W      = 16;
  localparam int COEF_W     = 24;
  localparam int PROD_W     = SMP_W + COEF_W;
  localparam int ACC_W      = 44;
  localparam int FRAC_BITS  = 20;
  localparam int BIT_CNT_W  = $clog2(SMP_W);
  localparam int TERM_W     = 3;
  localparam int IDX_W      = 3;

  localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd4;

  typedef struct packed {
    logic start;
    logic clear;
    logic negate;
  } mac_ctl_t;
endpackage

// ===== hdl/iir_mac.sv =====
// ----------------------------------------------------------------------------
// iir_mac
// Bit-serial multiply-accumulate: the sample is shifted out MSB first, one
// bit per cycle, and the product is added to or subtracted from the sum.
// ----------------------------------------------------------------------------
module iir_mac
  import iir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [SMP_W-1:0]  operand,
  output logic                     done,
  output logic signed [ACC_W-1:0]  acc
);
  logic                     run_r, run_nxt;
  logic                     add_r, add_nxt;
  logic [BIT_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SMP_W-1:0]         sh_r, sh_nxt;
  logic signed [COEF_W-1:0] coef_r, coef_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [PROD_W-1:0] p_r, p_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] addend;
  logic signed [ACC_W-1:0]  p_ext;

  always_comb begin
    addend = '0;
    if (sh_r[SMP_W-1]) begin
      if (cnt_r == '0) begin
        addend = -PROD_W'(coef_r);
      end else begin
        addend = PROD_W'(coef_r);
      end
    end
    p_ext = ACC_W'(p_r);
  end

  always_comb begin
    run_nxt  = run_r;
    add_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    coef_nxt = coef_r;
    neg_nxt  = neg_r;
    p_nxt    = p_r;
    acc_nxt  = acc_r;
    if (ctl.start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = operand;
      coef_nxt = coef;
      neg_nxt  = ctl.negate;
      p_nxt    = '0;
      if (ctl.clear) begin
        acc_nxt = '0;
      end
    end else if (run_r) begin
      p_nxt   = (p_r <<< 1) + addend;
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BIT_CNT_W'(SMP_W - 1)) begin
        run_nxt = 1'b0;
        add_nxt = 1'b1;
      end
    end else if (add_r) begin
      acc_nxt = neg_r ? acc_r - p_ext : acc_r + p_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      add_r <= 1'b0;
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      run_r <= run_nxt;
      add_r <= add_nxt;
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
    end
    sh_r   <= sh_nxt;
    coef_r <= coef_nxt;
    neg_r  <= neg_nxt;
    p_r    <= p_nxt;
  end

  assign done = add_r;
  assign acc  = acc_r;
endmodule

// ===== hdl/iir_direct_form_filter.sv =====
// ----------------------------------------------------------------------------
// iir_direct_form_filter
// Direct form I IIR filter up to third order on one bit-serial MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_sample_in takes one signed 16-bit
//   sample per request. Output channel out_valid/out_ready carries
//   out_sample_out (rounded, saturated) and out_saturated.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the Q4.20
//   coefficients b0..b3 (index 0..3) and a1..a3 (index 4..6); other indexes
//   are ignored. cfg_ready is always high; write only while idle.
//   Each sample runs 7 multiply-accumulates on the one serial MAC, each
//   made of a start step, the bit-serial pass over the sample and an
//   accumulate step; the sum is then rounded and saturated, and the next
//   request is taken only in the idle state after that rounding step.
//   The result sits in an output register; the next sample is taken while
//   it waits. If it is still not taken when the next result is ready, the
//   filter holds in its rounding step until out_ready.
//   Reset clears coefficients, histories and all valid flags.
// ----------------------------------------------------------------------------
module iir_direct_form_filter
  import iir_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] in_sample_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_sample_out,
  output logic                    out_saturated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [COEF_W-1:0]       cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [TERM_W-1:0]        term_r, term_nxt;
  logic signed [COEF_W-1:0] coef_r [NUM_REGS];
  logic signed [SMP_W-1:0]  x_r;
  logic signed [SMP_W-1:0]  xh_r [HIST_DEPTH];
  logic signed [SMP_W-1:0]  yh_r [HIST_DEPTH];
  logic                     out_valid_r;
  logic signed [SMP_W-1:0]  out_smp_r;
  logic                     out_sat_r;

  mac_ctl_t                 ctl;
  logic signed [COEF_W-1:0] mac_coef;
  logic signed [SMP_W-1:0]  mac_opnd;
  logic                     mac_done;
  logic signed [ACC_W-1:0]  mac_acc;
  logic [1:0]               k;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-FRAC_BITS-1:0] yw;
  logic                     sat;
  logic signed [SMP_W-1:0]  ysat;
  logic                     fin_go;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    k        = term_r[2:1] + {1'b0, term_r[0]};
    mac_coef = coef_r[REG_B0];
    mac_opnd = x_r;
    ctl      = '0;
    if (term_r[0]) begin
      mac_coef = coef_r[IDX_W'(k)];
      mac_opnd = xh_r[k - 2'd1];
    end else if (term_r != '0) begin
      mac_coef = coef_r[REG_A1 + IDX_W'(k) - 3'd1];
      mac_opnd = yh_r[k - 2'd1];
      ctl.negate = 1'b1;
    end
    ctl.start = (state_r == S_ISSUE);
    ctl.clear = (term_r == '0);
  end

  iir_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .coef    (mac_coef),
    .operand (mac_opnd),
    .done    (mac_done),
    .acc     (mac_acc)
  );

  always_comb begin
    rnd  = mac_acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
    yw   = rnd[ACC_W-1:FRAC_BITS];
    sat  = (yw[ACC_W-FRAC_BITS-1:SMP_W-1] != '0) && (yw[ACC_W-FRAC_BITS-1:SMP_W-1] != '1);
    ysat = yw[SMP_W-1:0];
    if (sat) begin
      ysat = yw[ACC_W-FRAC_BITS-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ISSUE;
          term_nxt  = '0;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (mac_done) begin
          if (term_r == TERM_W'(NUM_TERMS - 1)) begin
            state_nxt = S_FIN;
          end else begin
            term_nxt  = term_r + 1'b1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= '0;
      end
      for (int i = 0; i < HIST_DEPTH; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      if (cfg_valid && (cfg_index < IDX_W'(NUM_REGS))) begin
        coef_r[cfg_index] <= cfg_data;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
        xh_r[0] <= x_r;
        yh_r[0] <= ysat;
        for (int i = 1; i < HIST_DEPTH; i++) begin
          xh_r[i] <= xh_r[i-1];
          yh_r[i] <= yh_r[i-1];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      x_r <= in_sample_in;
    end
    if (fin_go) begin
      out_smp_r <= ysat;
      out_sat_r <= sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_smp_r;
  assign out_saturated  = out_sat_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_WAIT)
    else $error("MAC finished outside wait state");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ISSUE && term_r == '0))
    else $error("accepted request did not start first term");
  a_fin_output: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("result not presented after rounding");
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the direct form I IIR filter: a built-in fixed-point
// predictor tracks coefficients and sample histories, the driver feeds samples
// in random bursts, the monitor checks every result against the predictor.
// ----------------------------------------------------------------------------
module testbench
  import iir_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 6000;

  typedef struct {
    logic signed [SMP_W-1:0] smp;
    logic                    sat;
  } filt_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [SMP_W-1:0] in_sample_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SMP_W-1:0] out_sample_out;
  logic                    out_saturated;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [COEF_W-1:0]       cfg_data = '0;

  logic signed [SMP_W-1:0]  sample_queue[$];
  filt_result_t             expected_outputs[$];
  logic signed [COEF_W-1:0] coef_mirror[NUM_REGS];
  logic signed [SMP_W-1:0]  x_hist[HIST_DEPTH];
  logic signed [SMP_W-1:0]  y_hist[HIST_DEPTH];

  int errors = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int saturations_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int pattern_age = 0;
  logic [15:0] ready_pattern = 16'hffff;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  iir_direct_form_filter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic filt_result_t filter_sample(input logic signed [SMP_W-1:0] x);
    filt_result_t r;
    longint acc;
    longint y;
    acc = longint'(coef_mirror[0]) * longint'(x);
    for (int k = 1; k <= MAX_ORDER; k++) begin
      acc += longint'(coef_mirror[k]) * longint'(x_hist[k-1]);
      acc -= longint'(coef_mirror[3+k]) * longint'(y_hist[k-1]);
    end
    y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    r.sat = 1'b0;
    if (y > 32767) begin
      y = 32767;
      r.sat = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      r.sat = 1'b1;
    end
    r.smp = y[SMP_W-1:0];
    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = r.smp;
    return r;
  endfunction

  function automatic void queue_sample(input logic signed [SMP_W-1:0] s);
    sample_queue.insert(sample_queue.size(), s);
  endfunction

  // driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_sample_in <= sample_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hffff;
        1: ready_pattern <= 16'h0000;
        default: ready_pattern <= 16'($urandom);
      endcase
      pattern_age <= $urandom_range(16, 200);
    end else begin
      ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
      pattern_age <= pattern_age - 1;
    end
    out_ready <= rst_n && ready_pattern[15];
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    filt_result_t exp_r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < NUM_REGS)
          coef_mirror[cfg_index] = cfg_data;
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        expected_outputs.insert(expected_outputs.size(), filter_sample(in_sample_in));
        samples_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result sample_out=%0d saturated=%0b",
                   $time, out_sample_out, out_saturated);
          errors++;
        end else begin
          exp_r = expected_outputs.pop_front();
          if (out_sample_out !== exp_r.smp) begin
            $display("%0t: sample_out expected %0d actual %0d",
                     $time, exp_r.smp, out_sample_out);
            errors++;
          end
          if (out_saturated !== exp_r.sat) begin
            $display("%0t: saturated expected %0b actual %0b",
                     $time, exp_r.sat, out_saturated);
            errors++;
          end
          if (exp_r.sat) saturations_seen++;
        end
        results_checked++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else if (sample_queue.size() == 0 && !in_valid && !cfg_valid &&
               expected_outputs.size() == 0)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results pending", $time, expected_outputs.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    int n;
    n = cfg_writes;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    wait (cfg_writes != n);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [COEF_W-1:0] b0, b1, b2, b3, a1, a2, a3);
    write_coef(REG_B0, b0);
    write_coef(REG_B0 + 3'd1, b1);
    write_coef(REG_B0 + 3'd2, b2);
    write_coef(REG_B0 + 3'd3, b3);
    write_coef(REG_A1, a1);
    write_coef(REG_A1 + 3'd1, a2);
    write_coef(REG_A1 + 3'd2, a3);
  endtask

  task automatic drain;
    wait (sample_queue.size() == 0 && !in_valid && expected_outputs.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] rand_sample(input int kind);
    case (kind)
      0: return SMP_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return SMP_W'($signed($urandom_range(0, 64)) - 32);
      default: return SMP_W'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] small_coef(input int mag);
    return COEF_W'($signed($urandom_range(0, 2 * mag)) - mag);
  endfunction

  initial begin
    logic signed [SMP_W-1:0] lvl;
    int run_len;
    int kind;
    for (int i = 0; i < NUM_REGS; i++) coef_mirror[i] = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // zero coefficients after reset
    queue_sample(16'sh7fff);
    queue_sample(16'sh8000);
    drain();

    // unity gain and half-step rounding
    write_all(24'h100000, '0, '0, '0, '0, '0, '0);
    queue_sample(16'sh7fff);
    queue_sample(16'sh8000);
    queue_sample(16'sh0000);
    queue_sample(16'sh0001);
    queue_sample(16'shffff);
    drain();
    write_all(24'h080000, 24'h080000, '0, '0, '0, '0, '0);
    queue_sample(16'sh0001);
    queue_sample(16'shffff);
    queue_sample(16'shffff);
    queue_sample(16'sh0003);
    drain();

    // coefficient extremes and saturation both ways; index 7 is not a register
    write_all(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000,
              24'h7fffff, 24'h800000, 24'h7fffff);
    write_coef(3'd7, 24'hffffff);
    for (int i = 0; i < 6; i++)
      queue_sample(i[0] ? 16'sh8000 : 16'sh7fff);
    drain();
    write_all(24'h800000, 24'h800000, 24'h800000, 24'h800000,
              24'h800000, 24'h800000, 24'h800000);
    for (int i = 0; i < 6; i++)
      queue_sample(i < 3 ? 16'sh8000 : 16'sh0001);
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_all(small_coef(24'h040000), small_coef(24'h040000),
                     small_coef(24'h040000), small_coef(24'h040000),
                     small_coef(24'h060000), small_coef(24'h030000),
                     small_coef(24'h020000));
        1: write_all(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                     COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                     COEF_W'($urandom));
        2: write_all(small_coef(24'h200000), small_coef(24'h100000), '0, '0,
                     small_coef(24'h0c0000), '0, '0);
        default: write_all(24'h010000, 24'h030000, 24'h030000, 24'h010000,
                           24'hd00000, 24'h0a0000, 24'hfe0000);
      endcase
      for (int n = 0; n < 55; ) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          // step run at a constant level
          lvl = rand_sample($urandom_range(0, 3));
          run_len = $urandom_range(2, 12);
          for (int j = 0; j < run_len; j++) queue_sample(lvl);
          n += run_len;
        end else begin
          queue_sample(rand_sample(kind % 4));
          n++;
        end
      end
      drain();
    end

    $display("Ran %0d samples over %0d coefficient writes, checked %0d results",
             samples_sent, cfg_writes, results_checked);
    $display("%0d results saturated", saturations_seen);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/iir_pkg.sv
hdl/iir_mac.sv
hdl/iir_direct_form_filter.sv
tb/testbench.sv
